/* hdl/idlm_pkg.sv */
package idlm_pkg;

  localparam int IDX_W          = 12;
  localparam int TYPE_W         = 3;
  localparam int IDX_RANGE      = 1 << IDX_W;
  localparam int POOL_DEPTH_DEF = 4096;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ADD_HEAD  = 3'd0,
    REQ_ADD_TAIL  = 3'd1,
    REQ_MOVE_HEAD = 3'd2,
    REQ_MOVE_TAIL = 3'd3,
    REQ_REMOVE    = 3'd4,
    REQ_QUERY     = 3'd5
  } req_code_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_DECIDE,
    ST_UNLINK,
    ST_RD2,
    ST_DECIDE2,
    ST_LINK1,
    ST_LINK2,
    ST_DETACH,
    ST_RDF,
    ST_FIN
  } seq_state_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [IDX_W-1:0]  node_index;
  } req_t;

  typedef struct packed {
    logic             performed;
    logic             bad_index;
    logic [IDX_W-1:0] node_prev;
    logic [IDX_W-1:0] node_next;
    logic [IDX_W-1:0] head_index;
    logic [IDX_W-1:0] tail_index;
    logic             list_empty;
  } rsp_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } link_wr_t;

endpackage

/* hdl/indexed_dlist_manager.sv */
// states: query, skipped or bad requests go RD, DECIDE, FIN; add puts LINK1, LINK2, RDF
// before FIN, remove UNLINK, DETACH, RDF, move UNLINK, RD2, DECIDE2, LINK1, LINK2, RDF
// throughput: one request at a time, the next beat taken in the cycle after FIN hands
// on its result, which a receiver stall holds back; set by the single read and write
// port of each link memory; reset: synchronous, then a clearing pass links each of the
// min(POOL_DEPTH, 4096) entries to itself, no request taken meanwhile
module indexed_dlist_manager #(
  parameter int POOL_DEPTH = idlm_pkg::POOL_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  idlm_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output idlm_pkg::rsp_t rsp
);

  localparam int MEM_DEPTH = (POOL_DEPTH < idlm_pkg::IDX_RANGE) ? POOL_DEPTH
                                                                : idlm_pkg::IDX_RANGE;
  localparam int AW = $clog2(MEM_DEPTH);

  idlm_pkg::link_wr_t prev_wr;
  idlm_pkg::link_wr_t next_wr;
  idlm_pkg::rsp_t     res;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      prev_rd;
  logic [AW-1:0]      next_rd;
  logic [AW-1:0]      root_prev;
  logic [AW-1:0]      root_next;
  logic               res_valid;
  logic               res_take;

  idlm_seq #(.POOL_DEPTH(POOL_DEPTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .prev_rd   (prev_rd),
    .next_rd   (next_rd),
    .root_prev (root_prev),
    .root_next (root_next),
    .rd_addr   (rd_addr),
    .prev_wr   (prev_wr),
    .next_wr   (next_wr),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  idlm_ram #(.WIDTH(AW), .DEPTH(MEM_DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (prev_wr.en),
    .waddr (prev_wr.addr[AW-1:0]),
    .wdata (prev_wr.data[AW-1:0]),
    .raddr (rd_addr),
    .rdata (prev_rd)
  );

  idlm_ram #(.WIDTH(AW), .DEPTH(MEM_DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (next_wr.en),
    .waddr (next_wr.addr[AW-1:0]),
    .wdata (next_wr.data[AW-1:0]),
    .raddr (rd_addr),
    .rdata (next_rd)
  );

  // copy of the root entry
  always_ff @(posedge clk) begin
    if (rst) begin
      root_prev <= '0;
      root_next <= '0;
    end else begin
      if (prev_wr.en && (prev_wr.addr == '0)) begin
        root_prev <= prev_wr.data[AW-1:0];
      end
      if (next_wr.en && (next_wr.addr == '0)) begin
        root_next <= next_wr.data[AW-1:0];
      end
    end
  end

  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while previous one in progress");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (prev_wr.en || next_wr.en) |-> (req_stall && !res_valid))
    else $error("link write outside request processing");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.list_empty == (rsp.head_index == '0)))
    else $error("list_empty disagrees with head_index");

  a_bad_not_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.performed && rsp.bad_index))
    else $error("sentinel request reported as performed");

endmodule

/* hdl/idlm_ram.sv */
module idlm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/idlm_seq.sv */
module idlm_seq #(
  parameter int POOL_DEPTH = idlm_pkg::POOL_DEPTH_DEF,
  localparam int MEM_DEPTH = (POOL_DEPTH < idlm_pkg::IDX_RANGE) ? POOL_DEPTH
                                                                : idlm_pkg::IDX_RANGE,
  localparam int AW = $clog2(MEM_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  idlm_pkg::req_t     req,
  input  logic [AW-1:0]      prev_rd,
  input  logic [AW-1:0]      next_rd,
  input  logic [AW-1:0]      root_prev,
  input  logic [AW-1:0]      root_next,
  output logic [AW-1:0]      rd_addr,
  output idlm_pkg::link_wr_t prev_wr,
  output idlm_pkg::link_wr_t next_wr,
  output logic               res_valid,
  input  logic               res_take,
  output idlm_pkg::rsp_t     res
);

  localparam int IW = idlm_pkg::IDX_W;

  idlm_pkg::seq_state_t state, state_next;

  logic [idlm_pkg::TYPE_W-1:0] op, op_next;
  logic [AW-1:0] node, node_next;
  logic [AW-1:0] p, p_next;
  logic [AW-1:0] q, q_next;
  logic [AW-1:0] lnk, lnk_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic          done, done_next;
  logic          bad, bad_next;
  logic          in_pool, in_pool_next;
  logic          head_side;

  function automatic idlm_pkg::link_wr_t wr(logic [AW-1:0] addr, logic [AW-1:0] data);
    idlm_pkg::link_wr_t w;
    w.en   = 1'b1;
    w.addr = IW'(addr);
    w.data = IW'(data);
    return w;
  endfunction

  assign head_side = (op == idlm_pkg::REQ_ADD_HEAD) || (op == idlm_pkg::REQ_MOVE_HEAD);
  assign rd_addr   = node;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= idlm_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    node    <= node_next;
    p       <= p_next;
    q       <= q_next;
    lnk     <= lnk_next;
    done    <= done_next;
    bad     <= bad_next;
    in_pool <= in_pool_next;
  end

  always_comb begin
    state_next    = state;
    op_next       = op;
    node_next     = node;
    p_next        = p;
    q_next        = q;
    lnk_next      = lnk;
    done_next     = done;
    bad_next      = bad;
    in_pool_next  = in_pool;
    clr_addr_next = clr_addr;
    prev_wr       = '0;
    next_wr       = '0;
    req_stall     = 1'b1;
    res_valid     = 1'b0;
    unique case (state)
      idlm_pkg::ST_CLEAR: begin
        prev_wr       = wr(clr_addr, clr_addr);
        next_wr       = wr(clr_addr, clr_addr);
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == AW'(MEM_DEPTH - 1)) begin
          state_next = idlm_pkg::ST_IDLE;
        end
      end
      idlm_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          op_next      = req.req_type;
          node_next    = req.node_index[AW-1:0];
          bad_next     = (req.node_index == '0);
          in_pool_next = (32'(req.node_index) < 32'(POOL_DEPTH));
          done_next    = 1'b0;
          state_next   = idlm_pkg::ST_RD;
        end
      end
      idlm_pkg::ST_RD: begin
        state_next = idlm_pkg::ST_DECIDE;
      end
      idlm_pkg::ST_DECIDE: begin
        state_next = idlm_pkg::ST_FIN;
        p_next     = prev_rd;
        q_next     = next_rd;
        if (!bad && in_pool) begin
          unique case (op)
            idlm_pkg::REQ_ADD_HEAD: begin
              if (prev_rd != '0) begin
                lnk_next   = root_next;
                done_next  = 1'b1;
                state_next = idlm_pkg::ST_LINK1;
              end
            end
            idlm_pkg::REQ_ADD_TAIL: begin
              if (next_rd != '0) begin
                lnk_next   = root_prev;
                done_next  = 1'b1;
                state_next = idlm_pkg::ST_LINK1;
              end
            end
            idlm_pkg::REQ_MOVE_HEAD: begin
              if (prev_rd != '0) begin
                done_next  = 1'b1;
                state_next = idlm_pkg::ST_UNLINK;
              end
            end
            idlm_pkg::REQ_MOVE_TAIL: begin
              if (next_rd != '0) begin
                done_next  = 1'b1;
                state_next = idlm_pkg::ST_UNLINK;
              end
            end
            idlm_pkg::REQ_REMOVE: begin
              if (next_rd != node) begin
                done_next  = 1'b1;
                state_next = idlm_pkg::ST_UNLINK;
              end
            end
            default: begin
              state_next = idlm_pkg::ST_FIN;
            end
          endcase
        end
      end
      idlm_pkg::ST_UNLINK: begin
        prev_wr    = wr(q, p);
        next_wr    = wr(p, q);
        state_next = (op == idlm_pkg::REQ_REMOVE) ? idlm_pkg::ST_DETACH : idlm_pkg::ST_RD2;
      end
      idlm_pkg::ST_RD2: begin
        state_next = idlm_pkg::ST_DECIDE2;
      end
      idlm_pkg::ST_DECIDE2: begin
        state_next = idlm_pkg::ST_FIN;
        if (head_side) begin
          if (prev_rd != '0) begin
            lnk_next   = root_next;
            state_next = idlm_pkg::ST_LINK1;
          end
        end else begin
          if (next_rd != '0) begin
            lnk_next   = root_prev;
            state_next = idlm_pkg::ST_LINK1;
          end
        end
      end
      idlm_pkg::ST_LINK1: begin
        if (head_side) begin
          prev_wr = wr(lnk, node);
          next_wr = wr(node, lnk);
        end else begin
          prev_wr = wr('0, node);
          next_wr = wr(node, '0);
        end
        state_next = idlm_pkg::ST_LINK2;
      end
      idlm_pkg::ST_LINK2: begin
        if (head_side) begin
          prev_wr = wr(node, '0);
          next_wr = wr('0, node);
        end else begin
          prev_wr = wr(node, lnk);
          next_wr = wr(lnk, node);
        end
        state_next = idlm_pkg::ST_RDF;
      end
      idlm_pkg::ST_DETACH: begin
        prev_wr    = wr(node, node);
        next_wr    = wr(node, node);
        state_next = idlm_pkg::ST_RDF;
      end
      idlm_pkg::ST_RDF: begin
        state_next = idlm_pkg::ST_FIN;
      end
      idlm_pkg::ST_FIN: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = idlm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = idlm_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    res.performed  = done;
    res.bad_index  = bad;
    res.node_prev  = (bad || in_pool) ? IW'(prev_rd) : '0;
    res.node_next  = (bad || in_pool) ? IW'(next_rd) : '0;
    res.head_index = IW'(root_next);
    res.tail_index = IW'(root_prev);
    res.list_empty = (root_next == '0);
  end

endmodule

/* bench/tb_indexed_dlist_manager.sv */
module tb_indexed_dlist_manager;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW    = idlm_pkg::IDX_W;
  localparam int TW    = idlm_pkg::TYPE_W;
  localparam int DEPTH = idlm_pkg::POOL_DEPTH_DEF;

  localparam logic [TW-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [TW-1:0] REQ_SPARE7 = 3'd7;
  localparam logic [IW-1:0] ROOT       = '0;
  localparam logic [IW-1:0] TOP_IDX    = IW'(DEPTH - 1);
  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    idlm_pkg::req_t rq;
    logic           fixed;
    idlm_pkg::rsp_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  idlm_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  idlm_pkg::rsp_t rsp;

  logic [IW-1:0] prev_of [0:DEPTH-1];
  logic [IW-1:0] next_of [0:DEPTH-1];
  idlm_pkg::rsp_t rsp_pending [$];
  int mismatches = 0;
  int rsp_seen = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_now = 1'b0;

  indexed_dlist_manager dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got 0x%0h want 0x%0h", rsp_seen, what, got, want);
    mismatches++;
  endtask

  function automatic void link_in(input logic [IW-1:0] n, input logic [IW-1:0] p,
                                  input logic [IW-1:0] q);
    prev_of[q] = n;
    next_of[n] = q;
    prev_of[n] = p;
    next_of[p] = n;
  endfunction

  function automatic void cut_out(input logic [IW-1:0] n);
    logic [IW-1:0] p;
    logic [IW-1:0] q;
    p = prev_of[n];
    q = next_of[n];
    prev_of[q] = p;
    next_of[p] = q;
  endfunction

  function automatic bit splice_head(input logic [IW-1:0] n);
    if (prev_of[n] == ROOT) return 1'b0;
    link_in(n, ROOT, next_of[ROOT]);
    return 1'b1;
  endfunction

  function automatic bit splice_tail(input logic [IW-1:0] n);
    if (next_of[n] == ROOT) return 1'b0;
    link_in(n, prev_of[ROOT], ROOT);
    return 1'b1;
  endfunction

  function automatic idlm_pkg::rsp_t predict_links(input idlm_pkg::req_t r);
    logic [IW-1:0] n;
    idlm_pkg::rsp_t o;
    n = r.node_index;
    o = '0;
    if (n == ROOT) begin
      o.bad_index = 1'b1;
      o.node_prev = prev_of[ROOT];
      o.node_next = next_of[ROOT];
    end else begin
      case (r.req_type)
        idlm_pkg::REQ_ADD_HEAD: o.performed = splice_head(n);
        idlm_pkg::REQ_ADD_TAIL: o.performed = splice_tail(n);
        idlm_pkg::REQ_MOVE_HEAD: begin
          if (prev_of[n] != ROOT) begin
            cut_out(n);
            void'(splice_head(n));
            o.performed = 1'b1;
          end
        end
        idlm_pkg::REQ_MOVE_TAIL: begin
          if (next_of[n] != ROOT) begin
            cut_out(n);
            void'(splice_tail(n));
            o.performed = 1'b1;
          end
        end
        idlm_pkg::REQ_REMOVE: begin
          if (next_of[n] != n) begin
            cut_out(n);
            prev_of[n] = n;
            next_of[n] = n;
            o.performed = 1'b1;
          end
        end
        default: ;
      endcase
      o.node_prev = prev_of[n];
      o.node_next = next_of[n];
    end
    o.head_index = next_of[ROOT];
    o.tail_index = prev_of[ROOT];
    o.list_empty = (next_of[ROOT] == ROOT);
    return o;
  endfunction

  function automatic plan_row_t pred_row(input logic [TW-1:0] code,
                                         input logic [IW-1:0] idx);
    plan_row_t row;
    row = '0;
    row.rq.req_type = code;
    row.rq.node_index = idx;
    return row;
  endfunction

  function automatic plan_row_t fixed_row(input logic [TW-1:0] code,
                                          input logic [IW-1:0] idx,
                                          input idlm_pkg::rsp_t want);
    plan_row_t row;
    row = pred_row(code, idx);
    row.fixed = 1'b1;
    row.want = want;
    return row;
  endfunction

  // mostly well-formed traffic: adds only on detached nodes, small hot index set
  function automatic idlm_pkg::req_t make_random_req();
    idlm_pkg::req_t r;
    int roll;
    int pick;
    logic [IW-1:0] n;
    roll = $urandom_range(99);
    pick = $urandom_range(99);
    if (pick < 5) n = ROOT;
    else if (pick < 15 && next_of[ROOT] != ROOT) n = $urandom_range(1) ? next_of[ROOT]
                                                                       : prev_of[ROOT];
    else if (pick < 70) n = IW'($urandom_range(31, 1));
    else n = IW'($urandom_range(DEPTH - 1, 1));
    r.node_index = n;
    if (roll < 30) r.req_type = $urandom_range(1) ? idlm_pkg::REQ_ADD_HEAD
                                                  : idlm_pkg::REQ_ADD_TAIL;
    else if (roll < 58) r.req_type = $urandom_range(1) ? idlm_pkg::REQ_MOVE_HEAD
                                                       : idlm_pkg::REQ_MOVE_TAIL;
    else if (roll < 83) r.req_type = idlm_pkg::REQ_REMOVE;
    else if (roll < 93) r.req_type = idlm_pkg::REQ_QUERY;
    else r.req_type = $urandom_range(1) ? REQ_SPARE6 : REQ_SPARE7;
    if (r.req_type == idlm_pkg::REQ_ADD_HEAD && next_of[n] != n) begin
      r.req_type = idlm_pkg::REQ_MOVE_HEAD;
    end
    if (r.req_type == idlm_pkg::REQ_ADD_TAIL && next_of[n] != n) begin
      r.req_type = idlm_pkg::REQ_MOVE_TAIL;
    end
    return r;
  endfunction

  task automatic offer_req(input idlm_pkg::req_t r, input logic use_fixed,
                           input idlm_pkg::rsp_t fixed_rsp);
    idlm_pkg::rsp_t predicted;
    while (!calm && $urandom_range(99) < 24) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    predicted = predict_links(r);
    rsp_pending.push_back(use_fixed ? fixed_rsp : predicted);
  endtask

  // receiver side: random stall, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_now) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_now = 1'b0;
      end
      rsp_stall <= (!calm && $urandom_range(99) < 24);
    end
  end

  always @(posedge clk) begin
    idlm_pkg::rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (rsp_pending.size() == 0) begin
        flag_mismatch("unexpected beat", 1, 0);
      end else begin
        want = rsp_pending.pop_front();
        if (rsp.performed !== want.performed)
          flag_mismatch("performed", int'(rsp.performed), int'(want.performed));
        if (rsp.bad_index !== want.bad_index)
          flag_mismatch("bad_index", int'(rsp.bad_index), int'(want.bad_index));
        if (rsp.node_prev !== want.node_prev)
          flag_mismatch("node_prev", int'(rsp.node_prev), int'(want.node_prev));
        if (rsp.node_next !== want.node_next)
          flag_mismatch("node_next", int'(rsp.node_next), int'(want.node_next));
        if (rsp.head_index !== want.head_index)
          flag_mismatch("head_index", int'(rsp.head_index), int'(want.head_index));
        if (rsp.tail_index !== want.tail_index)
          flag_mismatch("tail_index", int'(rsp.tail_index), int'(want.tail_index));
        if (rsp.list_empty !== want.list_empty)
          flag_mismatch("list_empty", int'(rsp.list_empty), int'(want.list_empty));
      end
      rsp_seen++;
    end
  end

  initial begin
    plan_row_t plan [$];
    idlm_pkg::req_t r;
    int counted;
    bit held;
    bit paused;

    for (int i = 0; i < DEPTH; i++) begin
      prev_of[i] = IW'(i);
      next_of[i] = IW'(i);
    end

    // empty list, sentinel, extremes and guard skips
    plan.push_back(fixed_row(idlm_pkg::REQ_QUERY, ROOT,
                   idlm_pkg::rsp_t'{1'b0, 1'b1, ROOT, ROOT, ROOT, ROOT, 1'b1}));
    plan.push_back(fixed_row(idlm_pkg::REQ_QUERY, TOP_IDX,
                   idlm_pkg::rsp_t'{1'b0, 1'b0, TOP_IDX, TOP_IDX, ROOT, ROOT, 1'b1}));
    plan.push_back(fixed_row(idlm_pkg::REQ_REMOVE, 12'd1,
                   idlm_pkg::rsp_t'{1'b0, 1'b0, 12'd1, 12'd1, ROOT, ROOT, 1'b1}));
    plan.push_back(fixed_row(idlm_pkg::REQ_MOVE_HEAD, TOP_IDX,
                   idlm_pkg::rsp_t'{1'b1, 1'b0, ROOT, ROOT, TOP_IDX, TOP_IDX, 1'b0}));
    plan.push_back(fixed_row(idlm_pkg::REQ_ADD_HEAD, TOP_IDX,
                   idlm_pkg::rsp_t'{1'b0, 1'b0, ROOT, ROOT, TOP_IDX, TOP_IDX, 1'b0}));
    plan.push_back(fixed_row(idlm_pkg::REQ_ADD_TAIL, TOP_IDX,
                   idlm_pkg::rsp_t'{1'b0, 1'b0, ROOT, ROOT, TOP_IDX, TOP_IDX, 1'b0}));
    plan.push_back(pred_row(idlm_pkg::REQ_ADD_TAIL, 12'd1));
    // add of an attached node, then the remove and move that repair the ring
    plan.push_back(pred_row(idlm_pkg::REQ_ADD_TAIL, TOP_IDX));
    plan.push_back(pred_row(idlm_pkg::REQ_REMOVE, TOP_IDX));
    plan.push_back(pred_row(idlm_pkg::REQ_MOVE_HEAD, 12'd1));
    plan.push_back(pred_row(idlm_pkg::REQ_MOVE_TAIL, 12'd1));
    plan.push_back(pred_row(idlm_pkg::REQ_MOVE_TAIL, 12'd1));
    plan.push_back(pred_row(idlm_pkg::REQ_MOVE_HEAD, TOP_IDX));
    plan.push_back(pred_row(idlm_pkg::REQ_ADD_HEAD, 12'd2048));
    plan.push_back(pred_row(idlm_pkg::REQ_MOVE_HEAD, TOP_IDX));
    plan.push_back(pred_row(idlm_pkg::REQ_MOVE_TAIL, 12'd2048));
    plan.push_back(pred_row(idlm_pkg::REQ_MOVE_TAIL, 12'd3000));
    plan.push_back(pred_row(REQ_SPARE6, 12'd1));
    plan.push_back(pred_row(REQ_SPARE7, 12'd2048));
    plan.push_back(pred_row(REQ_SPARE7, ROOT));
    plan.push_back(pred_row(idlm_pkg::REQ_REMOVE, 12'd1));
    plan.push_back(pred_row(idlm_pkg::REQ_QUERY, 12'd2048));
    plan.push_back(pred_row(idlm_pkg::REQ_REMOVE, TOP_IDX));
    plan.push_back(pred_row(idlm_pkg::REQ_REMOVE, 12'd3000));
    plan.push_back(pred_row(idlm_pkg::REQ_REMOVE, 12'd2048));
    plan.push_back(fixed_row(idlm_pkg::REQ_ADD_HEAD, ROOT,
                   idlm_pkg::rsp_t'{1'b0, 1'b1, ROOT, ROOT, ROOT, ROOT, 1'b1}));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) offer_req(plan[i].rq, plan[i].fixed, plan[i].want);

    counted = 0;
    held = 1'b0;
    paused = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      calm = (counted >= 300 && counted < 700);
      if (counted == 1000 && !held) begin
        hold_now = 1'b1;
        held = 1'b1;
      end
      if (counted == 1500 && !paused) begin
        req_valid <= 1'b0;
        @(posedge clk);
        while (rsp_pending.size() != 0) @(posedge clk);
        paused = 1'b1;
      end
      r = make_random_req();
      offer_req(r, 1'b0, '0);
      counted++;
    end
    req_valid <= 1'b0;

    while (rsp_pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
